// ===== rtl/core/bfs_pkg.sv =====
// Shared types and constants for the breadth-first reachability search block.
// No dependencies; the interfaces and the top level import this package.
`timescale 1ns / 1ps
`default_nettype none

package bfs_pkg;

    localparam int NODE_W     = 3;
    localparam int COUNT_W    = 4;
    localparam int ADJ_W      = 64;
    localparam int ROW_STRIDE = 8;

    typedef logic [NODE_W-1:0]  node_t;
    typedef logic [COUNT_W-1:0] count_t;
    typedef logic [ADJ_W-1:0]   adj_t;

    typedef enum logic [1:0] {
        ST_VISITING = 2'd0,
        ST_REACHED  = 2'd1,
        ST_EXHAUSTED = 2'd2,
        ST_INVALID  = 2'd3
    } status_t;

    typedef enum logic {
        REG_ADJACENCY  = 1'b0,
        REG_NODE_COUNT = 1'b1
    } reg_index_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INVALID,
        S_POP,
        S_SCAN,
        S_EMIT
    } state_t;

    localparam count_t NODE_COUNT_RESET = 4'd5;

endpackage

`default_nettype wire

// ===== rtl/core/bfs_if.sv =====
// Valid/ready channel interfaces: query in, visited-node results out, config writes.
// Depends on bfs_pkg for field types.
`timescale 1ns / 1ps
`default_nettype none

interface bfs_query_if import bfs_pkg::*;;
    logic  valid;
    logic  ready;
    node_t start_node;
    node_t dest_node;

    modport source (output valid, output start_node, output dest_node, input ready);
    modport sink   (input valid, input start_node, input dest_node, output ready);
endinterface

interface bfs_result_if import bfs_pkg::*;;
    logic    valid;
    logic    ready;
    node_t   visited_node;
    status_t status;
    logic    last;

    modport source (output valid, output visited_node, output status, output last,
                    input ready);
    modport sink   (input valid, input visited_node, input status, input last,
                    output ready);
endinterface

interface bfs_cfg_if import bfs_pkg::*;;
    logic       valid;
    logic       ready;
    reg_index_t reg_index;
    adj_t       data;

    modport source (output valid, output reg_index, output data, input ready);
    modport sink   (input valid, input reg_index, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/bfs_reachability_search.sv =====
// Breadth-first reachability search over an adjacency bit matrix, one column per cycle.
// Depends on bfs_pkg and the channel interfaces in bfs_if.sv.
//
//   channel  dir  payload                              beat
//   query    in   start_node, dest_node                one per search
//   result   out  visited_node, status, last           one per visited node
//   cfg      in   reg_index, data                      one register write
//
// Each dequeued node passes through a pop step, a scan of all MAX_NODES columns in
// the shared compare step and an emit step; a node equal to dest_node is emitted
// from the pop step instead. An invalid query goes through S_INVALID only.
// Reset clears the sequencer, registers go to adjacency 0 and node_count 5.
// A stalled result beat holds the sequencer at its emit point; query is not
// accepted until the previous search has finished.
`timescale 1ns / 1ps
`default_nettype none

module bfs_reachability_search
    import bfs_pkg::*;
#(
    parameter int MAX_NODES = 8
) (
    input  wire              clk,
    input  wire              rst_n,
    bfs_query_if.sink        query,
    bfs_result_if.source     result,
    bfs_cfg_if.sink          cfg
);

    localparam int QW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int CW = $clog2(MAX_NODES + 1);
    localparam count_t MAX_LIMIT = COUNT_W'(MAX_NODES);
    localparam logic [QW-1:0] LAST_COL = QW'(MAX_NODES - 1);

    typedef logic [MAX_NODES-1:0] nodeset_t;

    state_t state_reg, state_next;

    adj_t   adjacency_reg;
    count_t node_count_reg;

    nodeset_t       visited_reg, visited_next;
    nodeset_t       row_reg, row_next;
    node_t          queue_reg [MAX_NODES];
    logic [QW-1:0]  head_reg, head_next;
    logic [QW-1:0]  tail_reg, tail_next;
    logic [CW-1:0]  count_reg, count_next;
    logic [QW-1:0]  col_reg, col_next;
    node_t          cur_reg, cur_next;
    node_t          dest_reg, dest_next;
    count_t         limit_reg, limit_next;

    logic    out_valid_reg, out_valid_next;
    node_t   out_node_reg, out_node_next;
    status_t out_status_reg, out_status_next;
    logic    out_last_reg, out_last_next;

    logic          push;
    node_t         push_node;
    logic [QW-1:0] push_addr;
    logic          slot_free;
    count_t        limit;
    node_t         head_node;
    logic          col_hit;

    assign cfg.ready   = 1'b1;
    assign query.ready = (state_reg == S_IDLE);

    assign result.valid        = out_valid_reg;
    assign result.visited_node = out_node_reg;
    assign result.status       = out_status_reg;
    assign result.last         = out_last_reg;

    assign slot_free = !out_valid_reg || result.ready;
    assign limit     = (node_count_reg > MAX_LIMIT) ? MAX_LIMIT : node_count_reg;
    assign head_node = queue_reg[head_reg];
    assign col_hit   = (COUNT_W'(col_reg) < limit_reg) && row_reg[col_reg]
                       && !visited_reg[col_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            adjacency_reg  <= '0;
            node_count_reg <= NODE_COUNT_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.reg_index)
                REG_ADJACENCY:  adjacency_reg  <= cfg.data;
                REG_NODE_COUNT: node_count_reg <= cfg.data[COUNT_W-1:0];
                default:        ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            visited_reg   <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            visited_reg   <= visited_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        row_reg        <= row_next;
        col_reg        <= col_next;
        cur_reg        <= cur_next;
        dest_reg       <= dest_next;
        limit_reg      <= limit_next;
        out_node_reg   <= out_node_next;
        out_status_reg <= out_status_next;
        out_last_reg   <= out_last_next;
        if (push)
        begin
            queue_reg[push_addr] <= push_node;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        visited_next    = visited_reg;
        row_next        = row_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        count_next      = count_reg;
        col_next        = col_reg;
        cur_next        = cur_reg;
        dest_next       = dest_reg;
        limit_next      = limit_reg;
        push            = 1'b0;
        push_node       = cur_reg;
        push_addr       = tail_reg;
        out_valid_next  = out_valid_reg && !result.ready;
        out_node_next   = out_node_reg;
        out_status_next = out_status_reg;
        out_last_next   = out_last_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (query.valid)
                begin
                    dest_next  = query.dest_node;
                    limit_next = limit;
                    head_next  = '0;
                    count_next = '0;
                    tail_next  = '0;
                    visited_next = '0;
                    if ((COUNT_W'(query.start_node) >= limit)
                        || (COUNT_W'(query.dest_node) >= limit))
                    begin
                        state_next = S_INVALID;
                    end
                    else
                    begin
                        // seed the queue with the start node
                        push         = 1'b1;
                        push_node    = query.start_node;
                        push_addr    = '0;
                        tail_next    = QW'(1);
                        count_next   = CW'(1);
                        visited_next = nodeset_t'(1) << query.start_node;
                        state_next   = S_POP;
                    end
                end
            end

            S_INVALID:
            begin
                if (slot_free)
                begin
                    out_valid_next  = 1'b1;
                    out_node_next   = '0;
                    out_status_next = ST_INVALID;
                    out_last_next   = 1'b1;
                    state_next      = S_IDLE;
                end
            end

            S_POP:
            begin
                if (head_node == dest_reg)
                begin
                    if (slot_free)
                    begin
                        out_valid_next  = 1'b1;
                        out_node_next   = head_node;
                        out_status_next = ST_REACHED;
                        out_last_next   = 1'b1;
                        state_next      = S_IDLE;
                    end
                end
                else
                begin
                    cur_next   = head_node;
                    head_next  = head_reg + QW'(1);
                    count_next = count_reg - CW'(1);
                    row_next   = adjacency_reg[{head_node, 3'b000} +: MAX_NODES];
                    col_next   = '0;
                    state_next = S_SCAN;
                end
            end

            S_SCAN:
            begin
                if (col_hit)
                begin
                    push         = 1'b1;
                    push_node    = NODE_W'(col_reg);
                    visited_next = visited_reg | (nodeset_t'(1) << col_reg);
                    tail_next    = tail_reg + QW'(1);
                    count_next   = count_reg + CW'(1);
                end
                col_next = col_reg + QW'(1);
                if (col_reg == LAST_COL)
                begin
                    state_next = S_EMIT;
                end
            end

            S_EMIT:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_node_next  = cur_reg;
                    if (count_reg == '0)
                    begin
                        out_status_next = ST_EXHAUSTED;
                        out_last_next   = 1'b1;
                        state_next      = S_IDLE;
                    end
                    else
                    begin
                        out_status_next = ST_VISITING;
                        out_last_next   = 1'b0;
                        state_next      = S_POP;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== test/tb_bfs_reachability_search.sv =====
// Self-checking testbench for bfs_reachability_search: random graphs and queries,
// with a breadth-first predictor and random stalls on both channels.
// Depends on bfs_pkg and the channel interfaces in rtl/core/bfs_if.sv.
`timescale 1ns / 1ps

module tb_bfs_reachability_search
    import bfs_pkg::*;
;

    localparam int NODE_LIMIT   = 8;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int HOLD_AT_BEAT = 150;
    localparam int LONG_HOLD    = 300;
    localparam int DRAIN_CYCLES = 100;
    localparam int RAND_PHASES  = 10;
    localparam int PHASE_ITEMS  = 30;

    typedef struct {
        node_t       start_node;
        node_t       dest_node;
        int unsigned gap;
    } search_query_t;

    typedef struct {
        node_t   node;
        status_t status;
        logic    last;
    } visit_t;

    logic clk;
    logic rst_n;

    bfs_query_if  query_ch ();
    bfs_result_if result_ch ();
    bfs_cfg_if    cfg_ch ();

    bfs_reachability_search #(
        .MAX_NODES (NODE_LIMIT)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .query  (query_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    // Register shadow, kept in step with accepted config beats
    adj_t   graph_edges;
    count_t graph_nodes;

    search_query_t pending_queries[$];
    visit_t        expected_visits[$];

    int unsigned mismatches;
    int unsigned beats_seen;
    int unsigned cycles;
    int unsigned gap_count;
    int unsigned stall_left;
    bit          steady_ready;
    bit          burst_mode;

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Breadth-first walk over the shadow graph; queue the visits it should emit.
    function automatic void expect_search(node_t start, node_t dest);
        int unsigned limit;
        logic [7:0]  seen;
        logic [7:0]  row;
        node_t       ring[NODE_LIMIT];
        int unsigned head;
        int unsigned tail;
        int unsigned queued;
        int unsigned emitted;
        int unsigned col;
        node_t       u;
        visit_t      v;

        limit = (graph_nodes > NODE_LIMIT) ? NODE_LIMIT : graph_nodes;
        if (start >= limit || dest >= limit) begin
            v.node   = '0;
            v.status = ST_INVALID;
            v.last   = 1'b1;
            expected_visits.push_back(v);
            return;
        end
        seen    = 8'b1 << start;
        ring[0] = start;
        head    = 0;
        tail    = 1;
        queued  = 1;
        emitted = 0;
        while (queued > 0 && emitted < NODE_LIMIT) begin
            u      = ring[head];
            head   = (head + 1) % NODE_LIMIT;
            queued = queued - 1;
            v.node = u;
            if (u == dest) begin
                v.status = ST_REACHED;
                v.last   = 1'b1;
                expected_visits.push_back(v);
                return;
            end
            row = graph_edges[u * ROW_STRIDE +: 8];
            for (col = 0; col < limit; col++) begin
                if (row[col] && !seen[col]) begin
                    seen[col] = 1'b1;
                    if (queued < NODE_LIMIT) begin
                        ring[tail] = node_t'(col);
                        tail       = (tail + 1) % NODE_LIMIT;
                        queued     = queued + 1;
                    end
                end
            end
            if (queued == 0) begin
                v.status = ST_EXHAUSTED;
                v.last   = 1'b1;
                expected_visits.push_back(v);
                return;
            end
            v.status = ST_VISITING;
            v.last   = 1'b0;
            expected_visits.push_back(v);
            emitted++;
        end
        // Ring cannot overrun with eight nodes; still close the search on the last visit
        if (emitted > 0) begin
            v        = expected_visits.pop_back();
            v.status = ST_EXHAUSTED;
            v.last   = 1'b1;
            expected_visits.push_back(v);
        end
    endfunction

    task automatic add_query(node_t start, node_t dest);
        search_query_t q;
        q.start_node = start;
        q.dest_node  = dest;
        q.gap        = burst_mode ? 0 : $urandom_range(0, 12);
        pending_queries.push_back(q);
    endtask

    task automatic write_reg(reg_index_t idx, adj_t value);
        @(posedge clk);
        cfg_ch.valid     <= 1'b1;
        cfg_ch.reg_index <= idx;
        cfg_ch.data      <= value;
        do @(posedge clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        if (idx == REG_ADJACENCY)
            graph_edges = value;
        else
            graph_nodes = count_t'(value[COUNT_W-1:0]);
        @(negedge clk);
    endtask

    task automatic wait_search_drain();
        do @(negedge clk);
        while (pending_queries.size() != 0 || query_ch.valid || expected_visits.size() != 0);
    endtask

    // Query driver: hold each beat until taken, idle for the item's gap before the next
    always @(posedge clk or negedge rst_n) begin : query_driver
        logic offer;
        if (!rst_n) begin
            query_ch.valid      <= 1'b0;
            query_ch.start_node <= '0;
            query_ch.dest_node  <= '0;
            gap_count = 0;
        end
        else begin
            offer = query_ch.valid;
            if (query_ch.valid && query_ch.ready) begin
                expect_search(query_ch.start_node, query_ch.dest_node);
                offer = 1'b0;
            end
            if (!offer && pending_queries.size() > 0) begin
                if (gap_count < pending_queries[0].gap)
                    gap_count++;
                else begin
                    query_ch.start_node <= pending_queries[0].start_node;
                    query_ch.dest_node  <= pending_queries[0].dest_node;
                    pending_queries.delete(0);
                    gap_count = 0;
                    offer     = 1'b1;
                end
            end
            query_ch.valid <= offer;
        end
    end

    // Result monitor: check each beat against the oldest expected visit, then stall
    always @(posedge clk or negedge rst_n) begin : visit_monitor
        visit_t want;
        if (!rst_n) begin
            result_ch.ready <= 1'b0;
            stall_left = 0;
        end
        else begin
            if (result_ch.valid && result_ch.ready) begin
                if (expected_visits.size() == 0) begin
                    $display("%0t: unexpected visit: expected none, got node %0d status %0d last %0b",
                             $time, result_ch.visited_node, result_ch.status, result_ch.last);
                    mismatches++;
                end
                else begin
                    want = expected_visits.pop_front();
                    if (want.node !== result_ch.visited_node) begin
                        $display("%0t: visited_node mismatch: expected %0d, got %0d",
                                 $time, want.node, result_ch.visited_node);
                        mismatches++;
                    end
                    if (want.status !== result_ch.status) begin
                        $display("%0t: status mismatch: expected %0d, got %0d",
                                 $time, want.status, result_ch.status);
                        mismatches++;
                    end
                    if (want.last !== result_ch.last) begin
                        $display("%0t: last mismatch: expected %0b, got %0b",
                                 $time, want.last, result_ch.last);
                        mismatches++;
                    end
                end
                beats_seen++;
                // one long hold-off so the block backs up and stalls its query input
                if (beats_seen == HOLD_AT_BEAT)
                    stall_left = LONG_HOLD;
                else if (steady_ready)
                    stall_left = 0;
                else
                    stall_left = $urandom_range(0, 12);
                if (beats_seen % 40 == 0)
                    steady_ready = ($urandom_range(0, 2) == 0);
            end
            else if (stall_left > 0)
                stall_left--;
            result_ch.ready <= (stall_left == 0);
        end
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin : test_sequence
        adj_t        chain;
        adj_t        edges;
        count_t      nodes;
        int unsigned lim;
        int          i;
        int          p;
        int          j;

        rst_n               = 1'b0;
        cfg_ch.valid        = 1'b0;
        cfg_ch.reg_index    = REG_ADJACENCY;
        cfg_ch.data         = '0;
        graph_edges         = '0;
        graph_nodes         = NODE_COUNT_RESET;
        burst_mode          = 1'b0;

        chain = '0;
        for (i = 0; i < NODE_LIMIT - 1; i++)
            chain[i * ROW_STRIDE + i + 1] = 1'b1;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset registers: no edges, five nodes
        add_query(3'd0, 3'd0);
        add_query(3'd2, 3'd3);
        add_query(3'd5, 3'd1);
        add_query(3'd1, 3'd7);
        wait_search_drain();

        // Complete graph with self loops, all eight nodes
        write_reg(REG_ADJACENCY, '1);
        write_reg(REG_NODE_COUNT, adj_t'(8));
        add_query(3'd0, 3'd7);
        add_query(3'd7, 3'd0);
        add_query(3'd3, 3'd3);
        wait_search_drain();

        // Ring: longest searches, eight visits each
        write_reg(REG_ADJACENCY, chain | (adj_t'(1) << (7 * ROW_STRIDE)));
        add_query(3'd0, 3'd7);
        add_query(3'd7, 3'd6);
        wait_search_drain();

        // Open chain, oversized node count clamps to eight
        write_reg(REG_ADJACENCY, chain);
        write_reg(REG_NODE_COUNT, adj_t'(15));
        add_query(3'd1, 3'd0);
        add_query(3'd0, 3'd7);
        wait_search_drain();

        // Edges into unused nodes are ignored
        write_reg(REG_ADJACENCY, '1);
        write_reg(REG_NODE_COUNT, adj_t'(6));
        add_query(3'd0, 3'd5);
        add_query(3'd0, 3'd6);
        add_query(3'd6, 3'd0);
        add_query(3'd5, 3'd5);
        wait_search_drain();

        // No nodes: every query invalid
        write_reg(REG_NODE_COUNT, adj_t'(0));
        add_query(3'd0, 3'd0);
        add_query(3'd7, 3'd7);
        wait_search_drain();

        write_reg(REG_NODE_COUNT, adj_t'(1));
        add_query(3'd0, 3'd0);
        add_query(3'd0, 3'd1);
        wait_search_drain();

        for (p = 0; p < RAND_PHASES; p++) begin
            case ($urandom_range(0, 3))
                0: edges = {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
                1: edges = {$urandom, $urandom};
                2: edges = {$urandom, $urandom} | {$urandom, $urandom};
                default: edges = {$urandom, $urandom} & {$urandom, $urandom};
            endcase
            case ($urandom_range(0, 5))
                0: nodes = count_t'($urandom_range(9, 15));
                1: nodes = count_t'($urandom_range(0, 1));
                default: nodes = count_t'($urandom_range(2, 8));
            endcase
            write_reg(REG_ADJACENCY, edges);
            write_reg(REG_NODE_COUNT, adj_t'(nodes));
            burst_mode = ($urandom_range(0, 3) == 0);
            lim = (nodes > NODE_LIMIT) ? NODE_LIMIT : nodes;
            for (j = 0; j < PHASE_ITEMS; j++) begin
                if (lim == 0 || $urandom_range(0, 6) == 0)
                    add_query(node_t'($urandom_range(0, 7)), node_t'($urandom_range(0, 7)));
                else
                    add_query(node_t'($urandom_range(0, lim - 1)),
                              node_t'($urandom_range(0, lim - 1)));
            end
            wait_search_drain();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ===== bfs_reachability_search.f =====
rtl/core/bfs_pkg.sv
rtl/core/bfs_if.sv
rtl/core/bfs_reachability_search.sv
test/tb_bfs_reachability_search.sv
